[rtl/c2tlb_pkg.sv]
// ----------------------------------------------------------------------------
// c2tlb_pkg: shared types and constants
// Request action codes, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package c2tlb_pkg;

   localparam int DATA_W      = 32;
   localparam int POS_W       = DATA_W + 1;
   localparam int USED_W      = 6;
   localparam int ROWCOL_W    = 5;
   localparam int ACTION_W    = 2;
   localparam int CSR_INDEX_W = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_WRITE  = 2'd0,
      ACT_LOOKUP = 2'd1,
      ACT_BOUNDS = 2'd2
   } action_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_OFFSET = 2'd0,
      CSR_COL_OFFSET = 2'd1,
      CSR_ROWS_USED  = 2'd2,
      CSR_COLS_USED  = 2'd3
   } csr_index_type;

endpackage

[rtl/c2tlb_matrix.sv]
// ----------------------------------------------------------------------------
// c2tlb_matrix: entry store
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module c2tlb_matrix #(
   parameter int DEPTH      = 1024,
   parameter int AW         = 10,
   parameter int VALUE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic signed [VALUE_BITS-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr,
   output logic signed [VALUE_BITS-1:0] rd_data
);

   logic signed [VALUE_BITS-1:0] store_mem [DEPTH];
   logic signed [VALUE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/c2tlb_span.sv]
// ----------------------------------------------------------------------------
// c2tlb_span: index range for one dimension
// Two register stages: offset removal, then clamp or intersect with the
// used range (empty intersection falls back to the whole used range).
// ----------------------------------------------------------------------------
module c2tlb_span #(
   parameter int DIM_MAX = 32,
   parameter int IW      = 5
) (
   input  logic                                  clock,
   input  logic                                  load,
   input  logic                                  point,
   input  logic signed [c2tlb_pkg::DATA_W-1:0]   lo,
   input  logic signed [c2tlb_pkg::DATA_W-1:0]   hi,
   input  logic signed [c2tlb_pkg::DATA_W-1:0]   offset,
   input  logic [c2tlb_pkg::USED_W-1:0]          used,
   output logic [IW-1:0]                         first,
   output logic [IW-1:0]                         last
);

   import c2tlb_pkg::*;

   logic signed [POS_W-1:0] lo_p_ff, lo_p_in;
   logic signed [POS_W-1:0] hi_p_ff, hi_p_in;
   logic                    point_ff;
   logic [IW-1:0]           lim_ff, lim_in;
   logic [IW-1:0]           first_ff, first_in;
   logic [IW-1:0]           last_ff, last_in;
   logic signed [POS_W-1:0] lim_s;
   logic                    empty;

   always_comb begin
      lo_p_in = POS_W'(lo) - POS_W'(offset);
      hi_p_in = POS_W'(hi) - POS_W'(offset);
      if (used == '0) begin
         lim_in = '0;
      end else if (int'(used) > DIM_MAX) begin
         lim_in = IW'(DIM_MAX - 1);
      end else begin
         lim_in = IW'(used - USED_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lo_p_ff  <= lo_p_in;
         hi_p_ff  <= hi_p_in;
         point_ff <= point;
         lim_ff   <= lim_in;
      end
   end

   assign lim_s = signed'(POS_W'(lim_ff));
   assign empty = (lo_p_ff > hi_p_ff) || (lo_p_ff > lim_s) || (hi_p_ff < 0);

   always_comb begin
      if (point_ff) begin
         if (lo_p_ff < 0) begin
            first_in = '0;
         end else if (lo_p_ff > lim_s) begin
            first_in = lim_ff;
         end else begin
            first_in = IW'(lo_p_ff);
         end
         last_in = first_in;
      end else if (empty) begin
         first_in = '0;
         last_in  = lim_ff;
      end else begin
         first_in = (lo_p_ff < 0) ? '0 : IW'(lo_p_ff);
         last_in  = (hi_p_ff > lim_s) ? lim_ff : IW'(hi_p_ff);
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      last_ff  <= last_in;
   end

   assign first = first_ff;
   assign last  = last_ff;

endmodule

[rtl/clamped_2d_table_lookup_bounds.sv]
// ----------------------------------------------------------------------------
// clamped_2d_table_lookup_bounds: clamped matrix lookup and rectangle bounds
// Write or unused: idle, then done. Lookup and bounds: idle, calc, setup,
// scan (one entry; R*C, at most MAX_ROWS*MAX_COLS, for an R x C box), drain, done.
// One request at a time; the single matrix read port scans one entry a cycle.
// Reset clears control and registers; matrix contents stay undefined.
// ----------------------------------------------------------------------------
module clamped_2d_table_lookup_bounds #(
   parameter int MAX_ROWS   = 32,
   parameter int MAX_COLS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [c2tlb_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [c2tlb_pkg::DATA_W-1:0]             csr_data,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [c2tlb_pkg::ACTION_W-1:0]           req_action,
   input  logic [c2tlb_pkg::ROWCOL_W-1:0]           req_write_row,
   input  logic [c2tlb_pkg::ROWCOL_W-1:0]           req_write_col,
   input  logic signed [c2tlb_pkg::DATA_W-1:0]      req_write_value,
   input  logic signed [c2tlb_pkg::DATA_W-1:0]      req_index_one,
   input  logic signed [c2tlb_pkg::DATA_W-1:0]      req_index_two,
   input  logic signed [c2tlb_pkg::DATA_W-1:0]      req_low_one,
   input  logic signed [c2tlb_pkg::DATA_W-1:0]      req_high_one,
   input  logic signed [c2tlb_pkg::DATA_W-1:0]      req_low_two,
   input  logic signed [c2tlb_pkg::DATA_W-1:0]      req_high_two,
   input  logic                                     req_widen_only,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [c2tlb_pkg::DATA_W-1:0]      rsp_looked_up_value,
   output logic signed [c2tlb_pkg::DATA_W-1:0]      rsp_min_value,
   output logic signed [c2tlb_pkg::DATA_W-1:0]      rsp_max_value,
   output logic                                     rsp_widen_flag
);

   import c2tlb_pkg::*;

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RB    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CB    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CALC  = 6'b000010,
      ST_SETUP = 6'b000100,
      ST_SCAN  = 6'b001000,
      ST_DRAIN = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type                    state_ff, state_in;
   logic signed [DATA_W-1:0]     row_offset_ff, row_offset_in;
   logic signed [DATA_W-1:0]     col_offset_ff, col_offset_in;
   logic [USED_W-1:0]            rows_used_ff, rows_used_in;
   logic [USED_W-1:0]            cols_used_ff, cols_used_in;
   logic [ACTION_W-1:0]          act_ff, act_in;
   logic                         widen_ff, widen_in;
   logic [RB-1:0]                row_ff, row_in;
   logic [CB-1:0]                col_ff, col_in;
   logic [AW-1:0]                row_base_ff, row_base_in;
   logic                         init_ff, init_in;
   logic                         rd_valid_ff, rd_valid_in;
   logic signed [VALUE_BITS-1:0] min_ff, min_in;
   logic signed [VALUE_BITS-1:0] max_ff, max_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]     rsp_lookup_ff, rsp_lookup_in;
   logic signed [DATA_W-1:0]     rsp_min_ff, rsp_min_in;
   logic signed [DATA_W-1:0]     rsp_max_ff, rsp_max_in;
   logic                         rsp_widen_ff, rsp_widen_in;

   logic                         accept;
   logic                         is_lookup;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic signed [VALUE_BITS-1:0] wr_data;
   logic                         rd_en;
   logic [AW-1:0]                rd_addr;
   logic signed [VALUE_BITS-1:0] rd_data;
   logic signed [DATA_W-1:0]     row_lo, row_hi, col_lo, col_hi;
   logic [RB-1:0]                row_first, row_last;
   logic [CB-1:0]                col_first, col_last;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_lookup = (req_action == ACT_LOOKUP);

   // configuration registers
   always_comb begin
      row_offset_in = row_offset_ff;
      col_offset_in = col_offset_ff;
      rows_used_in  = rows_used_ff;
      cols_used_in  = cols_used_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROW_OFFSET: row_offset_in = signed'(csr_data);
            CSR_COL_OFFSET: col_offset_in = signed'(csr_data);
            CSR_ROWS_USED:  rows_used_in  = csr_data[USED_W-1:0];
            CSR_COLS_USED:  cols_used_in  = csr_data[USED_W-1:0];
            default: ;
         endcase
      end
   end

   // matrix write on acceptance of a write request
   assign wr_en   = accept && (req_action == ACT_WRITE) &&
                    (int'(req_write_row) < MAX_ROWS) && (int'(req_write_col) < MAX_COLS);
   assign wr_addr = AW'(int'(req_write_row) * MAX_COLS + int'(req_write_col));
   assign wr_data = VALUE_BITS'(req_write_value);

   assign rd_en   = (state_ff == ST_SCAN);
   assign rd_addr = row_base_ff + AW'(col_ff);

   assign row_lo = is_lookup ? req_index_one : req_low_one;
   assign row_hi = is_lookup ? req_index_one : req_high_one;
   assign col_lo = is_lookup ? req_index_two : req_low_two;
   assign col_hi = is_lookup ? req_index_two : req_high_two;

   c2tlb_matrix #(
      .DEPTH      (DEPTH),
      .AW         (AW),
      .VALUE_BITS (VALUE_BITS)
   ) u_matrix (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   c2tlb_span #(
      .DIM_MAX (MAX_ROWS),
      .IW      (RB)
   ) u_row_span (
      .clock  (clock),
      .load   (accept),
      .point  (is_lookup),
      .lo     (row_lo),
      .hi     (row_hi),
      .offset (row_offset_ff),
      .used   (rows_used_ff),
      .first  (row_first),
      .last   (row_last)
   );

   c2tlb_span #(
      .DIM_MAX (MAX_COLS),
      .IW      (CB)
   ) u_col_span (
      .clock  (clock),
      .load   (accept),
      .point  (is_lookup),
      .lo     (col_lo),
      .hi     (col_hi),
      .offset (col_offset_ff),
      .used   (cols_used_ff),
      .first  (col_first),
      .last   (col_last)
   );

   // sequencer, scan and result register
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      widen_in      = widen_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      row_base_in   = row_base_ff;
      init_in       = init_ff && !rd_valid_ff;
      rd_valid_in   = rd_en;
      min_in        = min_ff;
      max_in        = max_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_lookup_in = rsp_lookup_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_widen_in  = rsp_widen_ff;

      if (rd_valid_ff) begin
         if (init_ff || (rd_data < min_ff)) begin
            min_in = rd_data;
         end
         if (init_ff || (rd_data > max_ff)) begin
            max_in = rd_data;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_in   = req_action;
               widen_in = req_widen_only;
               if ((req_action == ACT_LOOKUP) || (req_action == ACT_BOUNDS)) begin
                  state_in = ST_CALC;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_CALC: begin
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            row_in      = row_first;
            col_in      = col_first;
            row_base_in = AW'(AW'(row_first) * AW'(MAX_COLS));
            init_in     = 1'b1;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            if (col_ff == col_last) begin
               col_in = col_first;
               if (row_ff == row_last) begin
                  state_in = ST_DRAIN;
               end else begin
                  row_in      = row_ff + RB'(1);
                  row_base_in = row_base_ff + AW'(MAX_COLS);
               end
            end else begin
               col_in = col_ff + CB'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_lookup_in = (act_ff == ACT_LOOKUP) ? DATA_W'(min_ff) : '0;
               rsp_min_in    = (act_ff == ACT_BOUNDS) ? DATA_W'(min_ff) : '0;
               rsp_max_in    = (act_ff == ACT_BOUNDS) ? DATA_W'(max_ff) : '0;
               rsp_widen_in  = (act_ff == ACT_BOUNDS) && widen_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         row_offset_ff <= '0;
         col_offset_ff <= '0;
         rows_used_ff  <= USED_W'(32);
         cols_used_ff  <= USED_W'(32);
         init_ff       <= 1'b0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_offset_ff <= row_offset_in;
         col_offset_ff <= col_offset_in;
         rows_used_ff  <= rows_used_in;
         cols_used_ff  <= cols_used_in;
         init_ff       <= init_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      widen_ff      <= widen_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      row_base_ff   <= row_base_in;
      min_ff        <= min_in;
      max_ff        <= max_in;
      rsp_lookup_ff <= rsp_lookup_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_widen_ff  <= rsp_widen_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_looked_up_value = rsp_lookup_ff;
   assign rsp_min_value       = rsp_min_ff;
   assign rsp_max_value       = rsp_max_ff;
   assign rsp_widen_flag      = rsp_widen_ff;

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for clamped_2d_table_lookup_bounds
// Loads table entries, then runs clamped point lookups and rectangle min/max
// scans under several register settings. An in-bench model predicts each
// result, which is checked field by field in order. Both handshakes idle at
// random, and the result side also holds off for one long stretch.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import c2tlb_pkg::*;

   localparam int TABLE_ROWS  = 32;
   localparam int TABLE_COLS  = 32;
   localparam int LONG_HOLD   = 300;
   localparam int STALL_LIMIT = 20000;
   localparam int PRINT_LIMIT = 50;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam logic signed [DATA_W-1:0] INT_LOW  = 32'h8000_0000;
   localparam logic signed [DATA_W-1:0] INT_HIGH = 32'h7fff_ffff;

   typedef struct {
      logic [ACTION_W-1:0]      action;
      logic [ROWCOL_W-1:0]      write_row;
      logic [ROWCOL_W-1:0]      write_col;
      logic signed [DATA_W-1:0] write_value;
      logic signed [DATA_W-1:0] index_one;
      logic signed [DATA_W-1:0] index_two;
      logic signed [DATA_W-1:0] low_one;
      logic signed [DATA_W-1:0] high_one;
      logic signed [DATA_W-1:0] low_two;
      logic signed [DATA_W-1:0] high_two;
      logic                     widen_only;
   } table_request_type;

   typedef struct {
      logic signed [DATA_W-1:0] looked_up_value;
      logic signed [DATA_W-1:0] min_value;
      logic signed [DATA_W-1:0] max_value;
      logic                     widen_flag;
   } table_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [DATA_W-1:0]        csr_data  = '0;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [ACTION_W-1:0]      req_action      = '0;
   logic [ROWCOL_W-1:0]      req_write_row   = '0;
   logic [ROWCOL_W-1:0]      req_write_col   = '0;
   logic signed [DATA_W-1:0] req_write_value = '0;
   logic signed [DATA_W-1:0] req_index_one   = '0;
   logic signed [DATA_W-1:0] req_index_two   = '0;
   logic signed [DATA_W-1:0] req_low_one     = '0;
   logic signed [DATA_W-1:0] req_high_one    = '0;
   logic signed [DATA_W-1:0] req_low_two     = '0;
   logic signed [DATA_W-1:0] req_high_two    = '0;
   logic                     req_widen_only  = 1'b0;

   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_looked_up_value;
   logic signed [DATA_W-1:0] rsp_min_value;
   logic signed [DATA_W-1:0] rsp_max_value;
   logic                     rsp_widen_flag;

   clamped_2d_table_lookup_bounds #(
      .MAX_ROWS   (TABLE_ROWS),
      .MAX_COLS   (TABLE_COLS),
      .VALUE_BITS (DATA_W)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_write_row       (req_write_row),
      .req_write_col       (req_write_col),
      .req_write_value     (req_write_value),
      .req_index_one       (req_index_one),
      .req_index_two       (req_index_two),
      .req_low_one         (req_low_one),
      .req_high_one        (req_high_one),
      .req_low_two         (req_low_two),
      .req_high_two        (req_high_two),
      .req_widen_only      (req_widen_only),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_looked_up_value (rsp_looked_up_value),
      .rsp_min_value       (rsp_min_value),
      .rsp_max_value       (rsp_max_value),
      .rsp_widen_flag      (rsp_widen_flag)
   );

   // request queue, idling and bookkeeping
   table_request_type pending_requests[$];
   table_result_type  expected_results[$];
   int items_queued    = 0;
   int req_sent_count  = 0;
   int req_taken_count = 0;
   int csr_taken_count = 0;
   int send_idle_pct   = 0;
   int recv_idle_pct   = 0;
   int hold_asked      = 0;
   int hold_seen       = 0;
   int hold_left       = 0;
   int quiet_cycles    = 0;
   int mismatch_count  = 0;

   // predictor state
   logic signed [DATA_W-1:0] table_copy [0:TABLE_ROWS*TABLE_COLS-1];
   logic signed [DATA_W-1:0] pred_row_offset;
   logic signed [DATA_W-1:0] pred_col_offset;
   logic [USED_W-1:0]        pred_rows_used;
   logic [USED_W-1:0]        pred_cols_used;

   // stimulus view of the current setting
   logic signed [DATA_W-1:0] gen_row_offset;
   logic signed [DATA_W-1:0] gen_col_offset;
   int gen_rows;
   int gen_cols;
   bit entry_loaded [0:TABLE_ROWS*TABLE_COLS-1];

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int used_span(logic [USED_W-1:0] used, int limit);
      if (used == 0) return 1;
      if (int'(used) > limit) return limit;
      return int'(used);
   endfunction

   function automatic int clamp_position(logic signed [DATA_W-1:0] index,
                                         logic signed [DATA_W-1:0] offset, int dim);
      longint pos;
      pos = longint'(index) - longint'(offset);
      if (pos > dim - 1) pos = dim - 1;
      if (pos < 0) pos = 0;
      return int'(pos);
   endfunction

   // interval meets [offset, offset+dim-1]; an empty meet takes the whole range
   function automatic void clip_interval(input logic signed [DATA_W-1:0] low, high,
                                         input logic signed [DATA_W-1:0] offset,
                                         input int dim, output int first, output int last);
      longint lo_edge, hi_edge, top;
      top = longint'(offset) + dim - 1;
      lo_edge = (longint'(low) > longint'(offset)) ? longint'(low) : longint'(offset);
      hi_edge = (longint'(high) < top) ? longint'(high) : top;
      if (lo_edge > hi_edge) begin
         lo_edge = longint'(offset);
         hi_edge = top;
      end
      first = int'(lo_edge - longint'(offset));
      last  = int'(hi_edge - longint'(offset));
   endfunction

   function automatic table_result_type predict_result(table_request_type rq);
      table_result_type res;
      int rdim, cdim, r_first, r_last, c_first, c_last;
      logic signed [DATA_W-1:0] entry, low_seen, high_seen;
      res.looked_up_value = '0;
      res.min_value       = '0;
      res.max_value       = '0;
      res.widen_flag      = 1'b0;
      rdim = used_span(pred_rows_used, TABLE_ROWS);
      cdim = used_span(pred_cols_used, TABLE_COLS);
      case (rq.action)
         ACT_LOOKUP: begin
            res.looked_up_value =
               table_copy[clamp_position(rq.index_one, pred_row_offset, rdim) * TABLE_COLS
                          + clamp_position(rq.index_two, pred_col_offset, cdim)];
         end
         ACT_BOUNDS: begin
            clip_interval(rq.low_one, rq.high_one, pred_row_offset, rdim, r_first, r_last);
            clip_interval(rq.low_two, rq.high_two, pred_col_offset, cdim, c_first, c_last);
            low_seen  = table_copy[r_first * TABLE_COLS + c_first];
            high_seen = low_seen;
            for (int r = r_first; r <= r_last; r++) begin
               for (int c = c_first; c <= c_last; c++) begin
                  entry = table_copy[r * TABLE_COLS + c];
                  if (entry < low_seen) low_seen = entry;
                  if (entry > high_seen) high_seen = entry;
               end
            end
            res.min_value  = low_seen;
            res.max_value  = high_seen;
            res.widen_flag = rq.widen_only;
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic compare_field(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (got !== want) begin
         if (mismatch_count < PRINT_LIMIT)
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // monitor and predictor: everything sampled at the rising edge
   always @(posedge clock) begin : table_monitor
      table_request_type seen;
      table_result_type  want;
      if (reset) begin
         pred_row_offset = '0;
         pred_col_offset = '0;
         pred_rows_used  = 6'd32;
         pred_cols_used  = 6'd32;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROW_OFFSET: pred_row_offset = csr_data;
               CSR_COL_OFFSET: pred_col_offset = csr_data;
               CSR_ROWS_USED:  pred_rows_used  = csr_data[USED_W-1:0];
               CSR_COLS_USED:  pred_cols_used  = csr_data[USED_W-1:0];
               default: ;
            endcase
            csr_taken_count <= csr_taken_count + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               if (mismatch_count < PRINT_LIMIT)
                  $display("%0t: unexpected result, expected none, actual %0h %0h %0h %0b",
                           $time, rsp_looked_up_value, rsp_min_value, rsp_max_value,
                           rsp_widen_flag);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               compare_field("looked_up_value", want.looked_up_value, rsp_looked_up_value);
               compare_field("min_value", want.min_value, rsp_min_value);
               compare_field("max_value", want.max_value, rsp_max_value);
               compare_field("widen_flag", DATA_W'(want.widen_flag), DATA_W'(rsp_widen_flag));
            end
         end
         if (req_valid && req_ready) begin
            seen.action      = req_action;
            seen.write_row   = req_write_row;
            seen.write_col   = req_write_col;
            seen.write_value = req_write_value;
            seen.index_one   = req_index_one;
            seen.index_two   = req_index_two;
            seen.low_one     = req_low_one;
            seen.high_one    = req_high_one;
            seen.low_two     = req_low_two;
            seen.high_two    = req_high_two;
            seen.widen_only  = req_widen_only;
            expected_results.push_back(predict_result(seen));
            if (seen.action == ACT_WRITE)
               table_copy[int'(seen.write_row) * TABLE_COLS + int'(seen.write_col)] =
                  seen.write_value;
            req_taken_count <= req_taken_count + 1;
         end
      end
   end

   // request driver: falling edge, holds each request until taken
   always @(negedge clock) begin : request_driver
      table_request_type next_rq;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_taken_count != req_sent_count)) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_rq = pending_requests.pop_front();
            req_action      <= next_rq.action;
            req_write_row   <= next_rq.write_row;
            req_write_col   <= next_rq.write_col;
            req_write_value <= next_rq.write_value;
            req_index_one   <= next_rq.index_one;
            req_index_two   <= next_rq.index_two;
            req_low_one     <= next_rq.low_one;
            req_high_one    <= next_rq.high_one;
            req_low_two     <= next_rq.low_two;
            req_high_two    <= next_rq.high_two;
            req_widen_only  <= next_rq.widen_only;
            req_valid       <= 1'b1;
            req_sent_count  <= req_sent_count + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side: random stalls plus a long hold-off when the stimulus asks for one
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_asked) begin
         hold_seen <= hold_asked;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic signed [DATA_W-1:0] entry_value();
      case ($urandom_range(7))
         0: return INT_LOW;
         1: return INT_HIGH;
         2: return '0;
         3: return -1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] near_index(logic signed [DATA_W-1:0] offset,
                                                          int dim);
      int step;
      step = int'($urandom_range(dim + 5)) - 3;
      return offset + step;
   endfunction

   // every field but the action random; callers set the action and overwrite what it uses
   function automatic table_request_type random_request();
      table_request_type rq;
      rq.action      = ACT_UNUSED;
      rq.write_row   = ROWCOL_W'($urandom_range(TABLE_ROWS - 1));
      rq.write_col   = ROWCOL_W'($urandom_range(TABLE_COLS - 1));
      rq.write_value = $urandom;
      rq.index_one   = $urandom;
      rq.index_two   = $urandom;
      rq.low_one     = $urandom;
      rq.high_one    = $urandom;
      rq.low_two     = $urandom;
      rq.high_two    = $urandom;
      rq.widen_only  = 1'($urandom_range(1));
      return rq;
   endfunction

   task automatic queue_request(table_request_type rq);
      if (rq.action == ACT_WRITE)
         entry_loaded[int'(rq.write_row) * TABLE_COLS + int'(rq.write_col)] = 1'b1;
      pending_requests.push_back(rq);
      items_queued++;
   endtask

   task automatic queue_write(int row, int col, logic signed [DATA_W-1:0] value);
      table_request_type rq;
      rq = random_request();
      rq.action      = ACT_WRITE;
      rq.write_row   = ROWCOL_W'(row);
      rq.write_col   = ROWCOL_W'(col);
      rq.write_value = value;
      queue_request(rq);
   endtask

   task automatic queue_lookup(logic signed [DATA_W-1:0] row_index, col_index);
      table_request_type rq;
      rq = random_request();
      rq.action    = ACT_LOOKUP;
      rq.index_one = row_index;
      rq.index_two = col_index;
      queue_request(rq);
   endtask

   task automatic queue_bounds(logic signed [DATA_W-1:0] low_r, high_r, low_c, high_c,
                               logic widen);
      table_request_type rq;
      rq = random_request();
      rq.action     = ACT_BOUNDS;
      rq.low_one    = low_r;
      rq.high_one   = high_r;
      rq.low_two    = low_c;
      rq.high_two   = high_c;
      rq.widen_only = widen;
      queue_request(rq);
   endtask

   task automatic wait_until_drained();
      while (req_taken_count != items_queued || expected_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type index, logic [DATA_W-1:0] data);
      int target;
      target = csr_taken_count + 1;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(negedge clock); while (csr_taken_count != target);
      csr_valid <= 1'b0;
   endtask

   // registers change only with the block idle; the used region is loaded
   // before any read so no unwritten entry is ever looked at
   task automatic set_phase(logic [DATA_W-1:0] row_off, col_off,
                            logic [USED_W-1:0] rows, cols, int send_pct, recv_pct);
      logic [DATA_W-1:0] sized;
      wait_until_drained();
      write_csr(CSR_ROW_OFFSET, row_off);
      write_csr(CSR_COL_OFFSET, col_off);
      sized = $urandom;
      sized[USED_W-1:0] = rows;
      write_csr(CSR_ROWS_USED, sized);
      sized = $urandom;
      sized[USED_W-1:0] = cols;
      write_csr(CSR_COLS_USED, sized);
      gen_row_offset = row_off;
      gen_col_offset = col_off;
      gen_rows = used_span(rows, TABLE_ROWS);
      gen_cols = used_span(cols, TABLE_COLS);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int r = 0; r < gen_rows; r++)
         for (int c = 0; c < gen_cols; c++)
            if (!entry_loaded[r * TABLE_COLS + c]) queue_write(r, c, entry_value());
   endtask

   task automatic queue_random_mix(int count);
      table_request_type rq;
      int pick, shape;
      for (int i = 0; i < count; i++) begin
         rq = random_request();
         pick = $urandom_range(99);
         if (pick < 25) begin
            rq.action = ACT_WRITE;
            rq.write_value = entry_value();
         end else if (pick < 60) begin
            rq.action = ACT_LOOKUP;
            if ($urandom_range(9) < 7) begin
               rq.index_one = near_index(gen_row_offset, gen_rows);
               rq.index_two = near_index(gen_col_offset, gen_cols);
            end
         end else if (pick < 92) begin
            rq.action = ACT_BOUNDS;
            shape = $urandom_range(9);
            if (shape < 6) begin
               rq.low_one  = near_index(gen_row_offset, gen_rows);
               rq.high_one = near_index(gen_row_offset, gen_rows);
               rq.low_two  = near_index(gen_col_offset, gen_cols);
               rq.high_two = near_index(gen_col_offset, gen_cols);
            end else if (shape == 8) begin
               rq.low_one  = INT_LOW;
               rq.high_one = INT_HIGH;
               rq.low_two  = INT_LOW;
               rq.high_two = INT_HIGH;
            end else if (shape == 9) begin
               // intervals clear of the used range
               rq.low_one  = gen_row_offset + gen_rows + 2;
               rq.high_one = rq.low_one + 4;
               rq.low_two  = gen_col_offset - 9;
               rq.high_two = gen_col_offset - 1;
            end
         end else begin
            rq.action = ACT_UNUSED;
         end
         queue_request(rq);
      end
   endtask

   initial begin : stimulus
      table_request_type rq;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: 2x2 window, clamping at both ends, empty and inverted intervals
      set_phase(32'd10, -32'sd3, 6'd2, 6'd2, 19, 57);
      queue_write(0, 0, INT_LOW);
      queue_write(0, 1, INT_HIGH);
      queue_write(1, 0, 32'sd0);
      queue_write(1, 1, -32'sd1);
      queue_write(TABLE_ROWS - 1, TABLE_COLS - 1, 32'h5a5a_5a5a);
      queue_lookup(INT_LOW, INT_HIGH);
      queue_lookup(INT_HIGH, INT_LOW);
      queue_lookup(32'sd10, -32'sd3);
      queue_lookup(32'sd11, -32'sd2);
      queue_bounds(INT_LOW, INT_HIGH, INT_LOW, INT_HIGH, 1'b1);
      queue_bounds(32'sd20, 32'sd25, -32'sd3, -32'sd2, 1'b0);
      queue_bounds(32'sd11, 32'sd10, -32'sd3, -32'sd3, 1'b1);
      queue_bounds(32'sd11, 32'sd11, -32'sd2, -32'sd2, 1'b0);
      queue_bounds(-32'sd100, 32'sd10, 32'sd50, 32'sd60, 1'b1);
      rq = random_request();
      rq.action = ACT_UNUSED;
      queue_request(rq);
      queue_write(0, 0, 32'sd7);
      queue_lookup(32'sd10, -32'sd3);
      queue_bounds(32'sd10, 32'sd11, -32'sd3, -32'sd2, 1'b1);

      set_phase(-32'sd5, 32'd100, 6'd32, 6'd2, 19, 57);
      queue_random_mix(70);
      set_phase(INT_HIGH, INT_LOW, 6'd0, 6'd63, 19, 57);
      queue_random_mix(70);
      set_phase(INT_LOW, INT_HIGH, 6'd63, 6'd0, 57, 19);
      queue_random_mix(70);
      set_phase($urandom, $urandom, 6'd1, 6'd1, 57, 19);
      queue_random_mix(70);
      set_phase($urandom, $urandom, 6'($urandom_range(2, 8)), 6'($urandom_range(2, 8)), 0, 0);
      hold_asked <= hold_asked + 1;
      queue_random_mix(75);
      set_phase($urandom, $urandom, 6'd33, 6'd3, 0, 0);
      queue_random_mix(75);

      wait_until_drained();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[files.f]
rtl/c2tlb_pkg.sv
rtl/c2tlb_matrix.sv
rtl/c2tlb_span.sv
rtl/clamped_2d_table_lookup_bounds.sv
verif/tb.sv
